/* sv/mnp_pkg.sv */
// Shared types and MIDI status constants for the note message parser.
package mnp_pkg;

   // Status byte codes and masks
   localparam logic [7:0] STATUS_SYSEX_START = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_END   = 8'hF7;
   localparam logic [7:0] STATUS_MTC_QF      = 8'hF1;
   localparam logic [7:0] STATUS_SONG_POS    = 8'hF2;
   localparam logic [7:0] STATUS_SONG_SEL    = 8'hF3;
   localparam logic [3:0] HI_NOTE_OFF        = 4'h8;
   localparam logic [3:0] HI_NOTE_ON         = 4'h9;
   localparam logic [3:0] HI_PROG_CHANGE     = 4'hC;
   localparam logic [3:0] HI_CHAN_PRESSURE   = 4'hD;
   localparam logic [3:0] HI_SYSTEM          = 4'hF;
   localparam logic [7:0] CHANNEL_MASK       = 8'h0F;

   // One wire byte with its packet marker
   typedef struct packed {
      logic [7:0] midi_byte;
      logic       packet_start;
   } req_type;

   // One decoded note message
   typedef struct packed {
      logic [3:0] note_channel;
      logic [6:0] note_pitch;
      logic [6:0] note_velocity;
      logic       note_off;
   } note_type;

endpackage

/* sv/mnp_if.sv */
// Request and response channel interfaces of the note message parser.
interface mnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;
   logic       packet_start;

   modport source (output valid, output midi_byte, output packet_start, input ready);
   modport sink   (input valid, input midi_byte, input packet_start, output ready);
endinterface

interface mnp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] note_channel;
   logic [6:0] note_pitch;
   logic [6:0] note_velocity;
   logic       note_off;

   modport source (output valid, output note_channel, output note_pitch,
                   output note_velocity, output note_off, input ready);
   modport sink   (input valid, input note_channel, input note_pitch,
                   input note_velocity, input note_off, output ready);
endinterface

/* sv/mnp_in_stage.sv */
// Input register: holds one accepted request until the parser consumes it.
module mnp_in_stage
   import mnp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    advance,
   output logic    hold_valid,
   output req_type hold_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   // Accept when empty or when the held request moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

/* sv/mnp_core.sv */
// Parser state and per-byte decode with running status handling.
module mnp_core
   import mnp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  req_type  req_data,
   output logic     emit,
   output note_type note
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_COLLECT = 2'd1;
   localparam logic [1:0] PH_SKIP    = 2'd2;
   localparam logic [1:0] PH_DROP    = 2'd3;

   logic [7:0] rs_ff, rs_in;
   logic [1:0] phase_ff, phase_in;
   logic       expl_ff, expl_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [6:0] first_ff, first_in;
   logic [1:0] skip_ff, skip_in;

   logic [7:0] b;
   logic       do_start;
   logic       do_data;
   logic       need_one;
   logic [2:0] seen;

   assign b = req_data.midi_byte;

   // Decode one byte into next state and an optional note
   always_comb begin
      rs_in    = rs_ff;
      phase_in = phase_ff;
      expl_in  = expl_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      skip_in  = skip_ff;
      do_start = 1'b0;
      do_data  = 1'b0;
      need_one = 1'b0;
      seen     = 3'd0;
      emit     = 1'b0;
      note     = '0;

      // Packet start discards everything
      if (req_data.packet_start) begin
         rs_in    = 8'd0;
         phase_in = PH_IDLE;
         expl_in  = 1'b0;
         cnt_in   = 2'd0;
         first_in = 7'd0;
         skip_in  = 2'd0;
      end

      case (phase_in)
         PH_DROP: begin
         end
         PH_SKIP: begin
            if (skip_in != 2'd0) begin
               skip_in = skip_in - 2'd1;
            end
            if (skip_in == 2'd0) begin
               phase_in = PH_IDLE;
            end
         end
         PH_COLLECT: begin
            if (!b[7]) begin
               do_data = 1'b1;
            end else begin
               rs_in = 8'd0;
               seen  = {2'b00, expl_in} + {1'b0, cnt_in};
               if (seen == 3'd1) begin
                  do_start = 1'b1;
               end else begin
                  phase_in = PH_DROP;
                  expl_in  = 1'b0;
                  cnt_in   = 2'd0;
               end
            end
         end
         default: begin
            do_start = 1'b1;
         end
      endcase

      // Message start: data under running status, channel status or system byte
      if (do_start) begin
         expl_in = 1'b0;
         cnt_in  = 2'd0;
         if (!b[7]) begin
            if (!rs_in[7] || rs_in[7:4] == HI_SYSTEM) begin
               phase_in = PH_DROP;
            end else begin
               phase_in = PH_COLLECT;
               do_data  = 1'b1;
            end
         end else if (b[7:4] != HI_SYSTEM) begin
            rs_in    = b;
            expl_in  = 1'b1;
            phase_in = PH_COLLECT;
         end else if (b == STATUS_SYSEX_START || b == STATUS_SYSEX_END) begin
            phase_in = PH_DROP;
         end else if (b == STATUS_MTC_QF || b == STATUS_SONG_SEL) begin
            skip_in  = 2'd1;
            phase_in = PH_SKIP;
         end else if (b == STATUS_SONG_POS) begin
            skip_in  = 2'd2;
            phase_in = PH_SKIP;
         end else begin
            phase_in = PH_IDLE;
         end
      end

      // Collect a data byte, finish the message when complete
      if (do_data) begin
         need_one = (rs_in[7:4] == HI_PROG_CHANGE) || (rs_in[7:4] == HI_CHAN_PRESSURE);
         if (need_one || cnt_in != 2'd0) begin
            phase_in = PH_IDLE;
            expl_in  = 1'b0;
            cnt_in   = 2'd0;
            note.note_channel  = rs_in[3:0] & CHANNEL_MASK[3:0];
            note.note_pitch    = need_one ? b[6:0] : first_ff;
            note.note_velocity = need_one ? 7'd0 : b[6:0];
            note.note_off      = (rs_in[7:4] == HI_NOTE_OFF) || (note.note_velocity == 7'd0);
            emit = (rs_in[7:4] == HI_NOTE_OFF) || (rs_in[7:4] == HI_NOTE_ON);
         end else begin
            first_in = b[6:0];
            cnt_in   = 2'd1;
         end
      end
   end

   // Update state when a byte moves through
   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff    <= 8'd0;
         phase_ff <= PH_IDLE;
         expl_ff  <= 1'b0;
         cnt_ff   <= 2'd0;
         first_ff <= 7'd0;
         skip_ff  <= 2'd0;
      end else if (advance) begin
         rs_ff    <= rs_in;
         phase_ff <= phase_in;
         expl_ff  <= expl_in;
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
         skip_ff  <= skip_in;
      end
   end

`ifndef SYNTH
   // Collecting always runs under a channel status
   a_collect_status: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COLLECT |-> (rs_ff[7] && rs_ff[7:4] != HI_SYSTEM))
      else $error("collecting without channel status");

   // Skipping always has bytes left to skip
   a_skip_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != 2'd0)
      else $error("skip phase with nothing to skip");

   // Message bookkeeping is clear outside collection
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_COLLECT |-> (cnt_ff == 2'd0 && !expl_ff))
      else $error("stale message count outside collection");

   // A note leaves only from a collected message
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && !req_data.packet_start) |->
         (phase_ff == PH_COLLECT || phase_ff == PH_IDLE))
      else $error("note emitted from skip or drop");
`endif

endmodule

/* sv/mnp_out_stage.sv */
// Result register: holds one note until the response side takes it.
module mnp_out_stage
   import mnp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  note_type load_data,
   output logic     space,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output note_type rsp_data
);

   logic     valid_ff, valid_in;
   note_type data_ff;

   // Free when empty or being drained this cycle
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* sv/midi_note_message_parser.sv */
// Path: input register, core decode, result register, response port.
// One byte per cycle unless stalled; the input register frees as the result slot drains.
// A stalled response side holds the result register and then the input register.
// Reset (synchronous, active high) empties both registers and clears running status.
// After reset the parser is idle with no running status; no clearing pass is needed.
// Top level of the MIDI note message parser.
module midi_note_message_parser
   import mnp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mnp_req_if.sink   req_ch,
   mnp_rsp_if.source rsp_ch
);

   req_type  req_data;
   req_type  hold_data;
   logic     hold_valid;
   logic     advance;
   logic     space;
   logic     emit;
   note_type note;
   note_type out_data;

   assign req_data.midi_byte    = req_ch.midi_byte;
   assign req_data.packet_start = req_ch.packet_start;

   // Move the held byte through the parser when the result slot is free
   assign advance = hold_valid && space;

   mnp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_data   (req_data),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   mnp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_data (hold_data),
      .emit     (emit),
      .note     (note)
   );

   mnp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_data (note),
      .space     (space),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (out_data)
   );

   assign rsp_ch.note_channel  = out_data.note_channel;
   assign rsp_ch.note_pitch    = out_data.note_pitch;
   assign rsp_ch.note_velocity = out_data.note_velocity;
   assign rsp_ch.note_off      = out_data.note_off;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the MIDI note message parser with running status.
`timescale 1ns / 1ps

module testbench;
   import mnp_pkg::*;

   typedef enum logic [1:0] {
      PARSE_IDLE,
      PARSE_COLLECT,
      PARSE_SKIP,
      PARSE_DROP
   } parse_state_type;

   // Channel status high nibbles the package does not name
   localparam logic [3:0] HI_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] HI_CONTROL       = 4'hB;
   localparam logic [3:0] HI_PITCH_BEND    = 4'hE;
   // Stand-alone system bytes
   localparam logic [7:0] STATUS_CLOCK     = 8'hF8;
   localparam logic [7:0] STATUS_RESET     = 8'hFF;

   localparam int unsigned RANDOM_BYTES = 420;
   localparam int unsigned CYCLE_LIMIT  = 50000;
   localparam int unsigned DRAIN_CYCLES = 10;

   logic clock;
   logic reset;

   mnp_req_if req_bus ();
   mnp_rsp_if rsp_bus ();

   midi_note_message_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   req_type     wire_bytes[$];
   note_type    expected_notes[$];
   int unsigned total_bytes    = 0;
   int unsigned accepted_bytes = 0;
   int unsigned cycle_count    = 0;
   int unsigned error_count    = 0;
   int unsigned send_idle_pct  = 19;
   int unsigned recv_idle_pct  = 52;

   // Stimulus builder state
   logic       start_pending = 1'b0;
   logic [7:0] last_status   = {HI_NOTE_ON, 4'd0};

   // Parser state mirrored by the note predictor
   logic [7:0]      run_status;
   parse_state_type parse_state;
   logic            explicit_seen;
   logic [1:0]      data_seen;
   logic [6:0]      held_pitch;
   logic [1:0]      skips_left;

   // Clock: 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned data_bytes_for(logic [7:0] status);
      return (status[7:4] == HI_PROG_CHANGE || status[7:4] == HI_CHAN_PRESSURE) ? 1 : 2;
   endfunction

   function automatic void clear_parser();
      run_status    = 8'd0;
      parse_state   = PARSE_IDLE;
      explicit_seen = 1'b0;
      data_seen     = 2'd0;
      held_pitch    = 7'd0;
      skips_left    = 2'd0;
   endfunction

   // Close the message on its last data byte; queue a note for 8n/9n only
   function automatic void close_message(logic [7:0] last_byte);
      note_type   note;
      logic       single;
      logic [6:0] pitch;
      logic [6:0] velocity;
      single   = (data_bytes_for(run_status) == 1);
      pitch    = single ? last_byte[6:0] : held_pitch;
      velocity = single ? 7'd0 : last_byte[6:0];
      parse_state   = PARSE_IDLE;
      explicit_seen = 1'b0;
      data_seen     = 2'd0;
      if (run_status[7:4] == HI_NOTE_OFF || run_status[7:4] == HI_NOTE_ON) begin
         note.note_channel  = run_status[3:0];
         note.note_pitch    = pitch;
         note.note_velocity = velocity;
         note.note_off      = (run_status[7:4] == HI_NOTE_OFF) || (velocity == 7'd0);
         expected_notes = {expected_notes, note};
      end
   endfunction

   function automatic void take_data_byte(logic [7:0] b);
      if (data_seen + 1 >= data_bytes_for(run_status)) begin
         close_message(b);
      end else begin
         held_pitch = b[6:0];
         data_seen  = 2'd1;
      end
   endfunction

   // Handle a byte that opens a new message
   function automatic void begin_message(logic [7:0] b);
      explicit_seen = 1'b0;
      data_seen     = 2'd0;
      if (!b[7]) begin
         // data at message start needs a channel running status
         if (!run_status[7] || run_status[7:4] == HI_SYSTEM) begin
            parse_state = PARSE_DROP;
         end else begin
            parse_state = PARSE_COLLECT;
            take_data_byte(b);
         end
      end else if (b[7:4] != HI_SYSTEM) begin
         run_status    = b;
         explicit_seen = 1'b1;
         parse_state   = PARSE_COLLECT;
      end else if (b == STATUS_SYSEX_START || b == STATUS_SYSEX_END) begin
         parse_state = PARSE_DROP;
      end else if (b == STATUS_MTC_QF || b == STATUS_SONG_SEL) begin
         skips_left  = 2'd1;
         parse_state = PARSE_SKIP;
      end else if (b == STATUS_SONG_POS) begin
         skips_left  = 2'd2;
         parse_state = PARSE_SKIP;
      end else begin
         parse_state = PARSE_IDLE;
      end
   endfunction

   // Advance the parser by one accepted request
   function automatic void predict_notes(req_type r);
      logic [7:0] b;
      b = r.midi_byte;
      if (r.packet_start)
         clear_parser();
      case (parse_state)
         PARSE_DROP: ;
         PARSE_SKIP: begin
            if (skips_left != 2'd0)
               skips_left = skips_left - 2'd1;
            if (skips_left == 2'd0)
               parse_state = PARSE_IDLE;
         end
         PARSE_COLLECT: begin
            if (!b[7]) begin
               take_data_byte(b);
            end else begin
               // status inside data: restart after one byte, else drop the packet
               run_status = 8'd0;
               if (explicit_seen + data_seen == 1) begin
                  parse_state = PARSE_IDLE;
                  begin_message(b);
               end else begin
                  parse_state   = PARSE_DROP;
                  explicit_seen = 1'b0;
                  data_seen     = 2'd0;
               end
            end
         end
         default: begin_message(b);
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic push_byte(input logic [7:0] b);
      req_type r;
      r.midi_byte    = b;
      r.packet_start = start_pending;
      wire_bytes = {wire_bytes, r};
      start_pending = 1'b0;
   endtask

   task automatic push_start(input logic [7:0] b);
      start_pending = 1'b1;
      push_byte(b);
   endtask

   function automatic logic [7:0] random_data();
      return {1'b0, 7'($urandom_range(0, 127))};
   endfunction

   function automatic logic [7:0] random_velocity();
      if ($urandom_range(0, 7) == 0)
         return 8'd0;
      return {1'b0, 7'($urandom_range(1, 127))};
   endfunction

   function automatic logic [3:0] random_channel_hi();
      case ($urandom_range(0, 4))
         0:       return HI_POLY_PRESSURE;
         1:       return HI_CONTROL;
         2:       return HI_PROG_CHANGE;
         3:       return HI_CHAN_PRESSURE;
         default: return HI_PITCH_BEND;
      endcase
   endfunction

   // Push the data bytes that complete a message under the given status
   task automatic push_message_data(input logic [7:0] status);
      push_byte(random_data());
      if (data_bytes_for(status) == 2)
         push_byte(random_velocity());
   endtask

   // Build one packet: mostly well-formed messages, some noise and broken ones
   task automatic add_packet();
      int unsigned pick;
      logic [7:0]  st;
      start_pending = ($urandom_range(0, 9) != 0);
      repeat ($urandom_range(1, 4)) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            st = {($urandom_range(0, 1) ? HI_NOTE_ON : HI_NOTE_OFF), 4'($urandom_range(0, 15))};
            last_status = st;
            push_byte(st);
            push_message_data(st);
         end else if (pick < 55) begin
            // running status continuation
            push_message_data(last_status);
         end else if (pick < 65) begin
            st = {random_channel_hi(), 4'($urandom_range(0, 15))};
            last_status = st;
            push_byte(st);
            push_message_data(st);
         end else if (pick < 75) begin
            st = {HI_SYSTEM, 4'($urandom_range(0, 15))};
            push_byte(st);
            if (st == STATUS_MTC_QF || st == STATUS_SONG_SEL)
               push_byte(8'($urandom_range(0, 255)));
            else if (st == STATUS_SONG_POS)
               repeat (2) push_byte(8'($urandom_range(0, 255)));
         end else if (pick < 80) begin
            push_byte(STATUS_SYSEX_START);
            repeat ($urandom_range(0, 3)) push_byte(random_data());
            push_byte(STATUS_SYSEX_END);
         end else if (pick < 90) begin
            // status byte arrives where data is due
            st = {($urandom_range(0, 1) ? HI_NOTE_ON : random_channel_hi()),
                  4'($urandom_range(0, 15))};
            push_byte(st);
            if ($urandom_range(0, 1))
               push_byte(random_data());
            push_byte(8'($urandom_range(128, 255)));
            push_byte(random_data());
            push_byte(random_velocity());
         end else begin
            start_pending = start_pending | 1'($urandom_range(0, 1));
            push_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // ---------------------------------------------------------------- driver

   // Present requests from the queue and feed accepted ones to the predictor
   always @(posedge clock) begin : drive_requests
      req_type taken;
      req_type next_byte;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken.midi_byte    = req_bus.midi_byte;
            taken.packet_start = req_bus.packet_start;
            predict_notes(taken);
            accepted_bytes = accepted_bytes + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (wire_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_byte = wire_bytes.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.midi_byte    <= next_byte.midi_byte;
               req_bus.packet_start <= next_byte.packet_start;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         error_count = error_count + 1;
      end
   endtask

   // Compare each note against the oldest expectation; stall at random
   always @(posedge clock) begin : check_notes
      note_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_notes.size() == 0) begin
               $display("%0t: unexpected note: expected none, actual ch %0d pitch %0d vel %0d off %0d",
                        $time, rsp_bus.note_channel, rsp_bus.note_pitch,
                        rsp_bus.note_velocity, rsp_bus.note_off);
               error_count = error_count + 1;
            end else begin
               want = expected_notes.pop_front();
               check_field("note_channel", want.note_channel, rsp_bus.note_channel);
               check_field("note_pitch", want.note_pitch, rsp_bus.note_pitch);
               check_field("note_velocity", want.note_velocity, rsp_bus.note_velocity);
               check_field("note_off", want.note_off, rsp_bus.note_off);
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d notes still expected", $time, expected_notes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int unsigned directed_count;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.midi_byte    = 8'd0;
      req_bus.packet_start = 1'b0;
      rsp_bus.ready        = 1'b0;
      clear_parser();

      // data before any packet start, no running status: dropped
      push_byte(8'h45);
      // note on, then running status with velocity zero
      push_start({HI_NOTE_ON, 4'd0});
      push_byte(8'h3C);
      push_byte(8'h64);
      push_byte(8'h3E);
      push_byte(8'h00);
      // note off at the field extremes
      push_start({HI_NOTE_OFF, 4'hF});
      push_byte(8'h7F);
      push_byte(8'h7F);
      // real-time byte leaves running status alone
      push_byte(STATUS_CLOCK);
      push_byte(8'h00);
      push_byte(8'h01);
      // song position skips two bytes unchecked
      push_byte(STATUS_SONG_POS);
      push_byte({HI_NOTE_ON, 4'd0});
      push_byte(STATUS_RESET);
      // status after the status byte: restart on the new status
      push_byte({HI_NOTE_ON, 4'd0});
      push_byte({HI_NOTE_OFF, 4'd1});
      push_byte(8'h40);
      push_byte(8'h40);
      // song select skips one byte
      push_byte(STATUS_SONG_SEL);
      push_byte(8'h92);
      // status after two collected bytes: drop the rest of the packet
      push_byte({HI_NOTE_ON, 4'd10});
      push_byte(8'h40);
      push_byte({HI_NOTE_ON, 4'd1});
      push_byte(8'h40);
      // system exclusive drops, then a new packet with no running status
      push_start(STATUS_SYSEX_START);
      push_byte(8'h7E);
      push_start(8'h40);
      directed_count = wire_bytes.size();

      while (wire_bytes.size() < directed_count + RANDOM_BYTES)
         add_packet();
      total_bytes = wire_bytes.size();

      // hold reset, then release at a rising edge
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // swap the idle rates after a third, then stop idling
      while (accepted_bytes < total_bytes / 3) @(negedge clock);
      send_idle_pct = 52;
      recv_idle_pct = 19;
      while (accepted_bytes < 2 * total_bytes / 3) @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // drain
      while (accepted_bytes < total_bytes) @(posedge clock);
      while (expected_notes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
sv/mnp_pkg.sv
sv/mnp_if.sv
sv/mnp_in_stage.sv
sv/mnp_core.sv
sv/mnp_out_stage.sv
sv/midi_note_message_parser.sv
verif/testbench.sv
